// File: design/merge_sort_engine_macros.svh
// Assertion macros for the merge sort engine.
// Included by the sort sequencer and the top level; needs no package.
`ifndef MERGE_SORT_ENGINE_MACROS_SVH
`define MERGE_SORT_ENGINE_MACROS_SVH
`ifndef SYNTH
`define MSE_ASSERT(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("mse assertion failed");
`define MSE_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mse assertion failed");
`define MSE_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mse assertion failed");
`else
`define MSE_ASSERT(label, clk, rst, expr)
`define MSE_ASSERT_IMP(label, clk, rst, ante, cons)
`define MSE_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

// File: design/mse_pkg.sv
// Shared constants and types of the merge sort engine.
// No dependencies; used by the interfaces and all modules.
package mse_pkg;
   localparam int DATA_W        = 32;
   localparam int MAX_ITEMS_DEF = 64;

   typedef struct packed {
      logic done;
      logic src_b;
   } mse_seq_stat_type;
endpackage

// File: design/mse_req_if.sv
// Input channel of the merge sort engine: one value per word.
// Depends on mse_pkg.
interface mse_req_if
   import mse_pkg::*;
();
   logic                     valid;
   logic                     ready;
   logic signed [DATA_W-1:0] item_value;
   logic                     set_end;

   modport source(output valid, output item_value, output set_end, input ready);
   modport sink(input valid, input item_value, input set_end, output ready);
endinterface

// File: design/mse_rsp_if.sv
// Result channel of the merge sort engine: one sorted value per word.
// Depends on mse_pkg.
interface mse_rsp_if
   import mse_pkg::*;
();
   logic                     valid;
   logic                     ready;
   logic signed [DATA_W-1:0] sorted_value;
   logic                     final_flag;
   logic                     overflow;

   modport source(output valid, output sorted_value, output final_flag, output overflow,
                  input ready);
   modport sink(input valid, input sorted_value, input final_flag, input overflow,
                output ready);
endinterface

// File: design/mse_ram.sv
// Buffer memory: one write port, two read ports with registered data.
// Depends on mse_pkg.
module mse_ram
   import mse_pkg::*;
#(
   parameter int DEPTH = MAX_ITEMS_DEF,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              we,
   input  logic [AW-1:0]     waddr,
   input  logic [DATA_W-1:0] wdata,
   input  logic [AW-1:0]     raddr0,
   input  logic [AW-1:0]     raddr1,
   output logic [DATA_W-1:0] rdata0,
   output logic [DATA_W-1:0] rdata1
);
   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DATA_W-1:0] rd0_ff;
   logic [DATA_W-1:0] rd1_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rd0_ff <= mem_ff[raddr0];
      rd1_ff <= mem_ff[raddr1];
   end

   assign rdata0 = rd0_ff;
   assign rdata1 = rd1_ff;
endmodule

// File: design/mse_merge_seq.sv
// Bottom-up merge pass sequencer around one shared signed comparator.
// Depends on mse_pkg and merge_sort_engine_macros.svh.
`include "merge_sort_engine_macros.svh"
module mse_merge_seq
   import mse_pkg::*;
#(
   parameter int MAX_ITEMS = MAX_ITEMS_DEF,
   parameter int AW        = $clog2(MAX_ITEMS),
   parameter int CW        = $clog2(MAX_ITEMS + 1)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [CW-1:0]     count,
   input  logic [DATA_W-1:0] rd0,
   input  logic [DATA_W-1:0] rd1,
   output logic [AW-1:0]     raddr0,
   output logic [AW-1:0]     raddr1,
   output logic              we,
   output logic [AW-1:0]     waddr,
   output logic [DATA_W-1:0] wdata,
   output mse_seq_stat_type  stat
);
   localparam int PW = CW + 2;

   typedef enum logic [3:0] {
      S_IDLE  = 4'b0001,
      S_RUN   = 4'b0010,
      S_MERGE = 4'b0100,
      S_DONE  = 4'b1000
   } seq_state_type;

   seq_state_type state_ff, state_in;
   logic          src_b_ff, src_b_in;
   logic [PW-1:0] n_ff, n_in;
   logic [PW-1:0] w_ff, w_in;
   logic [PW-1:0] lo_ff, lo_in;
   logic [PW-1:0] mid_ff, mid_in;
   logic [PW-1:0] hi_ff, hi_in;
   logic [PW-1:0] i_ff, i_in;
   logic [PW-1:0] j_ff, j_in;
   logic [PW-1:0] k_ff, k_in;

   logic [PW-1:0] mid_c, hi_c, mid_sum, hi_sum, next_lo, w_dbl, i_nx, j_nx;
   logic          take_left;

   assign take_left = (i_ff < mid_ff) &&
                      ((j_ff >= hi_ff) || ($signed(rd0) <= $signed(rd1)));
   assign mid_sum   = lo_ff + w_ff;
   assign hi_sum    = lo_ff + (w_ff << 1);
   assign mid_c     = (mid_sum > n_ff) ? n_ff : mid_sum;
   assign hi_c      = (hi_sum > n_ff) ? n_ff : hi_sum;
   assign next_lo   = hi_sum;
   assign w_dbl     = w_ff << 1;
   assign i_nx      = i_ff + PW'(take_left);
   assign j_nx      = j_ff + PW'(!take_left);

   always_comb begin
      state_in = state_ff;
      src_b_in = src_b_ff;
      n_in     = n_ff;
      w_in     = w_ff;
      lo_in    = lo_ff;
      mid_in   = mid_ff;
      hi_in    = hi_ff;
      i_in     = i_ff;
      j_in     = j_ff;
      k_in     = k_ff;
      raddr0   = i_ff[AW-1:0];
      raddr1   = j_ff[AW-1:0];
      we       = 1'b0;
      waddr    = k_ff[AW-1:0];
      wdata    = take_left ? rd0 : rd1;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               n_in     = PW'(count);
               w_in     = PW'(1);
               lo_in    = '0;
               src_b_in = 1'b0;
               state_in = (count <= CW'(1)) ? S_DONE : S_RUN;
            end
         end
         S_RUN: begin
            i_in     = lo_ff;
            j_in     = mid_c;
            k_in     = lo_ff;
            mid_in   = mid_c;
            hi_in    = hi_c;
            raddr0   = lo_ff[AW-1:0];
            raddr1   = mid_c[AW-1:0];
            state_in = S_MERGE;
         end
         S_MERGE: begin
            we     = 1'b1;
            i_in   = i_nx;
            j_in   = j_nx;
            k_in   = k_ff + PW'(1);
            raddr0 = i_nx[AW-1:0];
            raddr1 = j_nx[AW-1:0];
            if (k_ff + PW'(1) == hi_ff) begin
               if (next_lo >= n_ff) begin
                  src_b_in = !src_b_ff;
                  w_in     = w_dbl;
                  lo_in    = '0;
                  state_in = (w_dbl >= n_ff) ? S_DONE : S_RUN;
               end else begin
                  lo_in    = next_lo;
                  state_in = S_RUN;
               end
            end
         end
         S_DONE: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         src_b_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         src_b_ff <= src_b_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff   <= n_in;
      w_ff   <= w_in;
      lo_ff  <= lo_in;
      mid_ff <= mid_in;
      hi_ff  <= hi_in;
      i_ff   <= i_in;
      j_ff   <= j_in;
      k_ff   <= k_in;
   end

   assign stat.done  = (state_ff == S_DONE);
   assign stat.src_b = src_b_ff;

   `MSE_ASSERT_IMP(a_start_idle, clock, reset, start, state_ff == S_IDLE)
   `MSE_ASSERT_IMP(a_k_in_run, clock, reset, state_ff == S_MERGE, k_ff < hi_ff)
   `MSE_ASSERT_IMP(a_merge_count, clock, reset, state_ff == S_MERGE, (k_ff + mid_ff) == (i_ff + j_ff))
endmodule

// File: design/merge_sort_engine.sv
// Top level of the merge sort engine: load, sort and emit control.
// Depends on mse_pkg, mse_req_if, mse_rsp_if, mse_ram, mse_merge_seq and the macros header.
//
// Usage: send signed values on req_ch, one per word; set_end marks the last value of a set.
// Up to MAX_ITEMS values are held; later values of the set are dropped and every result
// word of that set then carries overflow. After the word with set_end, req_ch.ready stays
// low while the set is sorted and emitted in ascending order on rsp_ch, final_flag on the
// last word. Loading accepts one word per cycle. The sort runs ceil(log2 n) merge passes
// through a single comparator, with a run setup state before each pair of runs is merged
// and a done state as handover. Emission moves each word through the registered read
// port of the buffer, in a fetch state and then a show state. The result register lets
// the next set start loading while the final word of the previous one still waits.
// A stalled rsp_ch holds the current word and emission pauses. Reset empties the set
// and the result register; buffer contents are not cleared and need no clearing.
`include "merge_sort_engine_macros.svh"
module merge_sort_engine
   import mse_pkg::*;
#(
   parameter int MAX_ITEMS = MAX_ITEMS_DEF
) (
   input logic          clock,
   input logic          reset,
   mse_req_if.sink      req_ch,
   mse_rsp_if.source    rsp_ch
);
   localparam int AW = $clog2(MAX_ITEMS);
   localparam int CW = $clog2(MAX_ITEMS + 1);

   typedef enum logic [3:0] {
      T_LOAD  = 4'b0001,
      T_SORT  = 4'b0010,
      T_FETCH = 4'b0100,
      T_SHOW  = 4'b1000
   } top_state_type;

   top_state_type state_ff, state_in;
   logic [CW-1:0] fill_ff, fill_in;
   logic          dropped_ff, dropped_in;
   logic [CW-1:0] emit_ff, emit_in;
   logic          res_b_ff, res_b_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0] value_ff;
   logic          final_ff;
   logic          ovf_ff;

   logic              accept, room, load_we, start, out_free, out_load, last_word;
   logic [CW-1:0]     seq_count;
   logic [AW-1:0]     seq_raddr0, seq_raddr1, seq_waddr, waddr, raddr0;
   logic              seq_we, we_a, we_b;
   logic [DATA_W-1:0] seq_wdata, wdata;
   logic [DATA_W-1:0] a_rd0, a_rd1, b_rd0, b_rd1, src_rd0, src_rd1, emit_rd;
   mse_seq_stat_type  seq_stat;

   assign req_ch.ready = (state_ff == T_LOAD);
   assign accept       = req_ch.valid && req_ch.ready;
   assign room         = fill_ff < CW'(MAX_ITEMS);
   assign load_we      = accept && room;
   assign start        = accept && req_ch.set_end;
   assign seq_count    = room ? fill_ff + CW'(1) : fill_ff;

   assign waddr  = (state_ff == T_LOAD) ? fill_ff[AW-1:0] : seq_waddr;
   assign wdata  = (state_ff == T_LOAD) ? DATA_W'(req_ch.item_value) : seq_wdata;
   assign we_a   = load_we || (seq_we && seq_stat.src_b);
   assign we_b   = seq_we && !seq_stat.src_b;
   assign raddr0 = (state_ff == T_SORT) ? seq_raddr0 : emit_ff[AW-1:0];

   assign src_rd0 = seq_stat.src_b ? b_rd0 : a_rd0;
   assign src_rd1 = seq_stat.src_b ? b_rd1 : a_rd1;
   assign emit_rd = res_b_ff ? b_rd0 : a_rd0;

   mse_ram #(.DEPTH(MAX_ITEMS), .AW(AW)) u_buf_a (
      .clock (clock),
      .we    (we_a),
      .waddr (waddr),
      .wdata (wdata),
      .raddr0(raddr0),
      .raddr1(seq_raddr1),
      .rdata0(a_rd0),
      .rdata1(a_rd1)
   );

   mse_ram #(.DEPTH(MAX_ITEMS), .AW(AW)) u_buf_b (
      .clock (clock),
      .we    (we_b),
      .waddr (waddr),
      .wdata (wdata),
      .raddr0(raddr0),
      .raddr1(seq_raddr1),
      .rdata0(b_rd0),
      .rdata1(b_rd1)
   );

   mse_merge_seq #(.MAX_ITEMS(MAX_ITEMS), .AW(AW), .CW(CW)) u_seq (
      .clock (clock),
      .reset (reset),
      .start (start),
      .count (seq_count),
      .rd0   (src_rd0),
      .rd1   (src_rd1),
      .raddr0(seq_raddr0),
      .raddr1(seq_raddr1),
      .we    (seq_we),
      .waddr (seq_waddr),
      .wdata (seq_wdata),
      .stat  (seq_stat)
   );

   assign out_free  = !rsp_valid_ff || rsp_ch.ready;
   assign out_load  = (state_ff == T_SHOW) && out_free;
   assign last_word = (emit_ff + CW'(1)) == fill_ff;

   always_comb begin
      state_in     = state_ff;
      fill_in      = fill_ff;
      dropped_in   = dropped_ff;
      emit_in      = emit_ff;
      res_b_in     = res_b_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         T_LOAD: begin
            if (accept) begin
               fill_in = seq_count;
               if (!room) begin
                  dropped_in = 1'b1;
               end
               if (req_ch.set_end) begin
                  state_in = T_SORT;
               end
            end
         end
         T_SORT: begin
            if (seq_stat.done) begin
               res_b_in = seq_stat.src_b;
               emit_in  = '0;
               state_in = T_FETCH;
            end
         end
         T_FETCH: begin
            state_in = T_SHOW;
         end
         T_SHOW: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               if (last_word) begin
                  fill_in    = '0;
                  dropped_in = 1'b0;
                  state_in   = T_LOAD;
               end else begin
                  emit_in  = emit_ff + CW'(1);
                  state_in = T_FETCH;
               end
            end
         end
         default: begin
            state_in = T_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= T_LOAD;
         fill_ff      <= '0;
         dropped_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         dropped_ff   <= dropped_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      emit_ff  <= emit_in;
      res_b_ff <= res_b_in;
      if (out_load) begin
         value_ff <= emit_rd;
         final_ff <= last_word;
         ovf_ff   <= dropped_ff;
      end
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.sorted_value = $signed(value_ff);
   assign rsp_ch.final_flag   = final_ff;
   assign rsp_ch.overflow     = ovf_ff;

   `MSE_ASSERT(a_fill_cap, clock, reset, fill_ff <= CW'(MAX_ITEMS))
   `MSE_ASSERT_IMP(a_done_in_sort, clock, reset, seq_stat.done, state_ff == T_SORT)
   `MSE_ASSERT_NXT(a_last_reopens, clock, reset, out_load && last_word, req_ch.ready && rsp_ch.valid)
endmodule

// File: tb/tb_merge_sort_engine.sv
`timescale 1ns / 1ps
// Testbench of merge_sort_engine: directed, capacity, back-pressure and random sets.
// Depends on mse_pkg, mse_req_if, mse_rsp_if and the merge_sort_engine RTL.
module tb_merge_sort_engine;
   import mse_pkg::*;

   localparam int CAP       = MAX_ITEMS_DEF;
   localparam int IDLE_MAX  = 5000;
   localparam int TAIL_WAIT = 40;
   localparam int RAND_ITEMS = 212;

   typedef enum int {
      FILL_RANDOM,
      FILL_NARROW,
      FILL_EXTREME,
      FILL_SHARED_HIGH
   } fill_mode_type;

   typedef struct {
      logic signed [DATA_W-1:0] value;
      logic                     last;
      logic                     ovf;
   } sorted_word_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   mse_req_if req_if ();
   mse_rsp_if rsp_if ();

   merge_sort_engine u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if),
      .rsp_ch (rsp_if)
   );

   sorted_word_type          sorted_q[$];
   logic signed [DATA_W-1:0] held_vals[CAP];
   int                       held_cnt = 0;
   logic                     held_lost = 1'b0;
   int                       errors = 0;
   int                       idle_cycles = 0;
   int                       rsp_hold_len = 0;
   bit                       req_gaps_on = 1'b1;
   bit                       rsp_gaps_on = 1'b1;

   always #5 clock = ~clock;

   initial begin
      req_if.valid      = 1'b0;
      req_if.item_value = '0;
      req_if.set_end    = 1'b0;
      rsp_if.ready      = 1'b0;
   end

   // hold each accepted input word and, on the last word of a set, sort the set
   task automatic absorb_value(input logic signed [DATA_W-1:0] value, input logic last);
      logic signed [DATA_W-1:0] arr[CAP];
      logic signed [DATA_W-1:0] key;
      sorted_word_type          w;
      int                       j;
      if (held_cnt < CAP) begin
         held_vals[held_cnt] = value;
         held_cnt++;
      end else begin
         held_lost = 1'b1;
      end
      if (last) begin
         for (int i = 0; i < held_cnt; i++) arr[i] = held_vals[i];
         for (int i = 1; i < held_cnt; i++) begin
            key = arr[i];
            j = i - 1;
            while (j >= 0 && arr[j] > key) begin
               arr[j + 1] = arr[j];
               j--;
            end
            arr[j + 1] = key;
         end
         for (int i = 0; i < held_cnt; i++) begin
            w.value = arr[i];
            w.last  = (i == held_cnt - 1);
            w.ovf   = held_lost;
            sorted_q.push_back(w);
         end
         held_cnt  = 0;
         held_lost = 1'b0;
      end
   endtask

   task automatic send_word(input logic signed [DATA_W-1:0] value, input logic last);
      int gap;
      gap = req_gaps_on ? $urandom_range(0, 15) : 0;
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid      <= 1'b1;
      req_if.item_value <= value;
      req_if.set_end    <= last;
      do @(posedge clock); while (!req_if.ready);
      absorb_value(value, last);
   endtask

   function automatic logic signed [DATA_W-1:0] pick_value(input fill_mode_type mode);
      logic signed [DATA_W-1:0] v;
      case (mode)
         FILL_NARROW: begin
            v = $signed(int'($urandom_range(0, 6)) - 3);
         end
         FILL_EXTREME: begin
            case ($urandom_range(0, 4))
               0: v = {1'b1, {(DATA_W-1){1'b0}}};
               1: v = {1'b0, {(DATA_W-1){1'b1}}};
               2: v = '0;
               3: v = '1;
               default: v = 1;
            endcase
         end
         FILL_SHARED_HIGH: begin
            v = {$urandom_range(0, 1) ? 24'hFFFFF0 : 24'h00000F, 8'($urandom)};
         end
         default: begin
            v = $urandom;
         end
      endcase
      return v;
   endfunction

   task automatic send_set(input int n, input fill_mode_type mode);
      for (int i = 0; i < n; i++) send_word(pick_value(mode), i == n - 1);
   endtask

   task automatic drain_results();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (sorted_q.size() != 0) @(posedge clock);
   endtask

   task automatic test_boundary_values();
      logic signed [DATA_W-1:0] mixed[8];
      mixed = '{32'sh7FFFFFFF, 32'sh80000000, 0, -1, 1, 32'sh55555555, 32'shAAAAAAAA,
                32'sh7FFFFFFF};
      send_word(32'sh80000000, 1'b1);
      send_word(32'sh7FFFFFFF, 1'b1);
      for (int i = 0; i < 8; i++) send_word(mixed[i], i == 7);
      for (int i = 0; i < 4; i++) send_word(-5, i == 3);
      for (int i = 0; i < 5; i++) send_word(10 - 2 * i, i == 4);
      for (int i = 0; i < 3; i++) send_word(i - 1, i == 2);
      drain_results();
   endtask

   task automatic test_capacity();
      send_set(CAP, FILL_RANDOM);
      send_set(CAP + 1, FILL_NARROW);
      send_set(CAP + 6, FILL_EXTREME);
      drain_results();
   endtask

   task automatic test_backpressure();
      rsp_hold_len = 600;
      send_set(12, FILL_RANDOM);
      send_set(7, FILL_SHARED_HIGH);
      send_set(3, FILL_NARROW);
      drain_results();
   endtask

   task automatic test_random_sets();
      int sent;
      int n;
      sent = 0;
      while (sent < RAND_ITEMS) begin
         case ($urandom_range(0, 31))
            0:       n = CAP + $urandom_range(1, 6);
            1, 2:    n = $urandom_range(30, CAP);
            default: n = $urandom_range(1, 12);
         endcase
         req_gaps_on = ($urandom_range(0, 3) != 0);
         rsp_gaps_on = ($urandom_range(0, 3) != 0);
         send_set(n, fill_mode_type'($urandom_range(0, 3)));
         sent += n;
      end
      req_gaps_on = 1'b1;
      rsp_gaps_on = 1'b1;
      drain_results();
   endtask

   initial begin : rsp_side
      sorted_word_type w;
      int              gap;
      while (reset) @(posedge clock);
      forever begin
         if (rsp_hold_len > 0) begin
            gap = rsp_hold_len;
            rsp_hold_len = 0;
         end else begin
            gap = rsp_gaps_on ? $urandom_range(0, 15) : 0;
         end
         if (gap > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
         do @(posedge clock); while (!rsp_if.valid);
         if (sorted_q.size() == 0) begin
            $error("unexpected result word: sorted_value %0d", rsp_if.sorted_value);
            errors++;
         end else begin
            w = sorted_q.pop_front();
            if (rsp_if.sorted_value !== w.value) begin
               $error("sorted_value: expected %0d, actual %0d", w.value, rsp_if.sorted_value);
               errors++;
            end
            if (rsp_if.final_flag !== w.last) begin
               $error("final_flag: expected %0b, actual %0b", w.last, rsp_if.final_flag);
               errors++;
            end
            if (rsp_if.overflow !== w.ovf) begin
               $error("overflow: expected %0b, actual %0b", w.ovf, rsp_if.overflow);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_MAX) begin
            $display("Verification failed");
            $finish;
         end
      end
   end

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_boundary_values();
      test_capacity();
      test_backpressure();
      test_random_sets();
      repeat (TAIL_WAIT) @(posedge clock);
      if (errors == 0 && sorted_q.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end
endmodule

// File: sim.f
+incdir+design
design/mse_pkg.sv
design/mse_req_if.sv
design/mse_rsp_if.sv
design/mse_ram.sv
design/mse_merge_seq.sv
design/merge_sort_engine.sv
tb/tb_merge_sort_engine.sv
